/* hw/rtl/text_stream_line_filter_unit_defines.svh */
// Assertion macros for the line filter back end.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef TEXT_STREAM_LINE_FILTER_UNIT_DEFINES_SVH
`define TEXT_STREAM_LINE_FILTER_UNIT_DEFINES_SVH

`define TSLF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TSLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tslf_pkg.sv */
package tslf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUMBER_NONBLANK  = 3'd0,
        CFG_NUMBER_ALL       = 3'd1,
        CFG_SQUEEZE_BLANK    = 3'd2,
        CFG_SHOW_NONPRINTING = 3'd3,
        CFG_SHOW_ENDS        = 3'd4,
        CFG_SHOW_TABS        = 3'd5
    } t_cfg_idx;

    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_CARET    = 8'h5E;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] CH_I        = 8'h49;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_CTRL_MAX = 8'h1F;
    localparam logic [7:0] CTRL_OFFSET = 8'h40;

    localparam int DIGITS = 6;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int SUB_W  = $clog2(DIGITS + 1);
    localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);
    localparam logic [BCD_W-1:0] BCD_MAX = 24'h999999;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0]       ch;
        logic             num;
        logic [BCD_W-1:0] bcd;
        logic             pad;
        logic             dollar;
        logic             caret;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_NUM,
        PH_PAD,
        PH_DOLLAR,
        PH_CARET,
        PH_FINAL
    } t_phase;

endpackage

/* hw/rtl/tslf_in_if.sv */
interface tslf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_file;

    modport source (output valid, output data_byte, output first_of_file, input ready);
    modport sink (input valid, input data_byte, input first_of_file, output ready);
endinterface

/* hw/rtl/tslf_out_if.sv */
interface tslf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* hw/rtl/tslf_front.sv */
module tslf_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tslf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tslf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tslf_in_if.sink                        i_in,
    input  logic                           i_full,
    output logic                           o_push,
    output tslf_pkg::t_cmd                 o_cmd
);
    import tslf_pkg::*;

    logic             r_number_nonblank, r_number_all, r_squeeze_blank;
    logic             r_show_nonprinting, r_show_ends, r_show_tabs;
    logic             r_prev, n_prev;
    logic             r_blank, n_blank;
    logic [BCD_W-1:0] r_cnt, n_cnt;

    logic             accept;
    logic             prev, blank, nl, drop, number_it, ctrl_caret;
    logic [BCD_W-1:0] cnt;
    logic [7:0]       c;

    function automatic logic [BCD_W-1:0] bcd_next(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             carry;
        r = v;
        carry = 1'b1;
        if (v != BCD_MAX) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (carry) begin
                    if (r[4*d +: 4] < 4'd9) begin
                        r[4*d +: 4] = r[4*d +: 4] + 4'd1;
                        carry = 1'b0;
                    end else begin
                        r[4*d +: 4] = 4'd0;
                    end
                end
            end
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_nonblank  <= 1'b0;
            r_number_all       <= 1'b0;
            r_squeeze_blank    <= 1'b0;
            r_show_nonprinting <= 1'b0;
            r_show_ends        <= 1'b0;
            r_show_tabs        <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NUMBER_NONBLANK:  r_number_nonblank  <= i_cfg_data[0];
                CFG_NUMBER_ALL:       r_number_all       <= i_cfg_data[0];
                CFG_SQUEEZE_BLANK:    r_squeeze_blank    <= i_cfg_data[0];
                CFG_SHOW_NONPRINTING: r_show_nonprinting <= i_cfg_data[0];
                CFG_SHOW_ENDS:        r_show_ends        <= i_cfg_data[0];
                CFG_SHOW_TABS:        r_show_tabs        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        prev  = i_in.first_of_file ? 1'b1 : r_prev;
        blank = i_in.first_of_file ? 1'b0 : r_blank;
        cnt   = i_in.first_of_file ? BCD_ONE : r_cnt;
        nl    = (i_in.data_byte == CH_NL);

        // A repeated blank line is dropped but still counts as a newline.
        drop    = r_squeeze_blank && prev && nl && blank;
        n_blank = r_squeeze_blank ? (prev && nl) : blank;
        n_prev  = nl;

        number_it = 1'b0;
        if (r_number_nonblank) begin
            number_it = prev && !nl;
        end else if (r_number_all) begin
            number_it = prev;
        end
        n_cnt = (number_it && !drop) ? bcd_next(cnt) : cnt;

        ctrl_caret = r_show_nonprinting &&
            (((i_in.data_byte <= CH_CTRL_MAX) && (i_in.data_byte != CH_TAB) && !nl) ||
             (i_in.data_byte == CH_DEL));

        c = i_in.data_byte;
        if (ctrl_caret) begin
            c = (i_in.data_byte == CH_DEL) ? CH_QMARK : i_in.data_byte + CTRL_OFFSET;
        end else if (r_show_tabs && (i_in.data_byte == CH_TAB)) begin
            c = CH_I;
        end

        o_cmd.ch     = c;
        o_cmd.num    = number_it;
        o_cmd.bcd    = cnt;
        o_cmd.dollar = r_show_ends && nl;
        o_cmd.pad    = r_show_ends && nl && r_number_nonblank && prev;
        o_cmd.caret  = ctrl_caret || (r_show_tabs && (i_in.data_byte == CH_TAB));
        o_push       = accept && !drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b1;
            r_blank <= 1'b0;
            r_cnt   <= BCD_ONE;
        end else if (accept) begin
            r_prev  <= n_prev;
            r_blank <= n_blank;
            r_cnt   <= n_cnt;
        end
    end
endmodule

/* hw/rtl/tslf_queue.sv */
module tslf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tslf_pkg::t_cmd i_wdata,
    output logic           o_full,
    input  logic           i_pop,
    output tslf_pkg::t_cmd o_rdata,
    output logic           o_empty
);
    import tslf_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

/* hw/rtl/tslf_back.sv */
`include "text_stream_line_filter_unit_defines.svh"

module tslf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  tslf_pkg::t_cmd i_cmd,
    output logic           o_pop,
    tslf_out_if.source     o_out
);
    import tslf_pkg::*;

    t_phase           r_phase, n_phase;
    logic [SUB_W-1:0] r_sub, n_sub;
    t_cmd             r_cmd, n_cmd;

    logic             out_xfer, last_sub;
    logic [7:0]       num_chars [DIGITS+1];
    logic             lead;
    logic [3:0]       dig;

    function automatic t_phase start_phase(input t_cmd c);
        priority if (c.num) return PH_NUM;
        else if (c.pad)     return PH_PAD;
        else if (c.dollar)  return PH_DOLLAR;
        else if (c.caret)   return PH_CARET;
        else                return PH_FINAL;
    endfunction

    always_comb begin
        lead = 1'b1;
        dig  = '0;
        for (int i = DIGITS - 1; i >= 0; i--) begin
            dig = r_cmd.bcd[4*i +: 4];
            if ((dig != 4'd0) || (i == 0)) begin
                lead = 1'b0;
            end
            num_chars[DIGITS-1-i] = lead ? CH_SPACE : (CH_ZERO + {4'd0, dig});
        end
        num_chars[DIGITS] = CH_TAB;
    end

    assign out_xfer = o_out.valid && o_out.ready;
    assign last_sub = (r_sub == SUB_W'(DIGITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sub   <= '0;
        end else begin
            r_phase <= n_phase;
            r_sub   <= n_sub;
        end
        r_cmd <= n_cmd;
    end

    always_comb begin
        n_phase = r_phase;
        n_sub   = r_sub;
        n_cmd   = r_cmd;
        o_pop   = 1'b0;

        o_out.valid       = (r_phase != PH_IDLE);
        o_out.last_of_run = (r_phase == PH_FINAL);
        o_out.out_byte    = r_cmd.ch;

        unique case (r_phase)
            PH_IDLE: begin
                o_out.out_byte = r_cmd.ch;
            end
            PH_NUM: begin
                o_out.out_byte = num_chars[r_sub];
                if (out_xfer) begin
                    if (!last_sub) begin
                        n_sub = r_sub + 1'b1;
                    end else begin
                        n_sub = '0;
                        priority if (r_cmd.pad) n_phase = PH_PAD;
                        else if (r_cmd.dollar)  n_phase = PH_DOLLAR;
                        else if (r_cmd.caret)   n_phase = PH_CARET;
                        else                    n_phase = PH_FINAL;
                    end
                end
            end
            PH_PAD: begin
                o_out.out_byte = last_sub ? CH_TAB : CH_SPACE;
                if (out_xfer) begin
                    if (!last_sub) begin
                        n_sub = r_sub + 1'b1;
                    end else begin
                        n_sub   = '0;
                        n_phase = PH_DOLLAR;
                    end
                end
            end
            PH_DOLLAR: begin
                o_out.out_byte = CH_DOLLAR;
                if (out_xfer) begin
                    n_phase = r_cmd.caret ? PH_CARET : PH_FINAL;
                end
            end
            PH_CARET: begin
                o_out.out_byte = CH_CARET;
                if (out_xfer) begin
                    n_phase = PH_FINAL;
                end
            end
            PH_FINAL: begin
                o_out.out_byte = r_cmd.ch;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // The next command is loaded in the cycle the last byte transfers.
        if ((r_phase == PH_IDLE) || ((r_phase == PH_FINAL) && out_xfer)) begin
            n_sub = '0;
            if (!i_empty) begin
                o_pop   = 1'b1;
                n_cmd   = i_cmd;
                n_phase = start_phase(i_cmd);
            end else begin
                n_phase = PH_IDLE;
            end
        end
    end

    `TSLF_ASSERT_NOW(a_num_cmd, r_phase == PH_NUM, r_cmd.num && !r_cmd.pad, "Number phase without a numbered command.")
    `TSLF_ASSERT_NOW(a_pad_cmd, r_phase == PH_PAD, r_cmd.pad && r_cmd.dollar, "Pad phase without an end mark.")
    `TSLF_ASSERT_NOW(a_sub_idle, (r_phase != PH_NUM) && (r_phase != PH_PAD), r_sub == '0, "Sub counter is not clear outside a multi-byte phase.")
    `TSLF_ASSERT_NEXT(a_drain, (r_phase == PH_FINAL) && o_out.ready && i_empty, r_phase == PH_IDLE, "Back end did not go idle after the last transfer.")
endmodule

/* hw/rtl/text_stream_line_filter_unit.sv */
// Text line filter: one input byte per transfer is turned into one to nine output bytes
// (a squeezed blank line gives none), with optional line numbers, caret notation, end marks
// and tab marks. The front end classifies each byte and registers the line state,
// so it takes a new byte every cycle while the four-entry command queue has room. The back
// end sends one output byte per cycle while the output is ready, so an input byte holds
// the output until all its bytes are sent: one for plain text, up to nine for a numbered
// line start. The output is the bottleneck; input stalls only when the queue fills.
module text_stream_line_filter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tslf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tslf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tslf_in_if.sink                        i_in,
    tslf_out_if.source                     o_out
);
    import tslf_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    t_cmd q_wdata, q_rdata;

    tslf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (q_wdata)
    );

    tslf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    tslf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cmd   (q_rdata),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );
endmodule

/* tb/text_stream_line_filter_unit_tb.sv */
`timescale 1ns / 1ps

module text_stream_line_filter_unit_tb;
    import tslf_pkg::*;

    localparam int CYCLE_LIMIT   = 1500000;
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_WAIT      = 17;
    localparam int PRINT_CAP     = 40;
    localparam int COUNT_LINES   = 100;
    localparam int PHASE_ITEMS   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_file;
    } t_text_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_filt_byte;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    tslf_in_if  in_if ();
    tslf_out_if out_if ();

    text_stream_line_filter_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #4 i_clk = ~i_clk;

    logic set_nonblank = 1'b0;
    logic set_all      = 1'b0;
    logic set_squeeze  = 1'b0;
    logic set_nonprint = 1'b0;
    logic set_ends     = 1'b0;
    logic set_tabs     = 1'b0;

    logic             at_line_start = 1'b1;
    logic             blank_held    = 1'b0;
    logic [BCD_W-1:0] line_num      = BCD_ONE;

    t_text_item pending_text[$];
    t_filt_byte expected_bytes[$];
    t_text_item next_text;
    t_filt_byte want;

    int   in_gap      = 0;
    int   out_stall   = 0;
    int   out_draw    = 0;
    int   mismatches  = 0;
    int   cycle_count = 0;
    logic quiet_phase = 1'b0;

    function automatic int draw_wait();
        if (quiet_phase || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [BCD_W-1:0] bcd_incr(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             carry;
        r = v;
        carry = 1'b1;
        if (v == BCD_MAX) return v;
        for (int d = 0; d < DIGITS; d++) begin
            if (carry) begin
                if (r[4*d +: 4] == 4'd9) begin
                    r[4*d +: 4] = 4'd0;
                end else begin
                    r[4*d +: 4] = r[4*d +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // Works out the output bytes of one input byte and advances the line state.
    task automatic expand_byte(input t_text_item item);
        logic [7:0] ch;
        logic       start;
        logic       nl;
        logic       numbered;
        logic       lead;
        logic [3:0] dig;
        logic [7:0] run[$];
        ch = item.data_byte;
        if (item.first_of_file) begin
            at_line_start = 1'b1;
            blank_held = 1'b0;
            line_num = BCD_ONE;
        end
        start = at_line_start;
        nl = (ch == CH_NL);
        if (set_squeeze) begin
            if (start && nl) begin
                if (blank_held) return;
                blank_held = 1'b1;
            end else begin
                blank_held = 1'b0;
            end
        end
        if (set_nonblank) begin
            numbered = start && !nl;
        end else begin
            numbered = set_all && start;
        end
        if (numbered) begin
            lead = 1'b1;
            for (int d = DIGITS - 1; d >= 0; d--) begin
                dig = line_num[4*d +: 4];
                if (dig != 4'd0 || d == 0) lead = 1'b0;
                run.push_back(lead ? CH_SPACE : CH_ZERO + {4'd0, dig});
            end
            run.push_back(CH_TAB);
            line_num = bcd_incr(line_num);
        end
        if (set_nonprint) begin
            if (ch <= CH_CTRL_MAX && ch != CH_TAB && ch != CH_NL) begin
                run.push_back(CH_CARET);
                ch = ch + CTRL_OFFSET;
            end else if (ch == CH_DEL) begin
                run.push_back(CH_CARET);
                ch = CH_QMARK;
            end
        end
        if (set_ends && nl) begin
            if (set_nonblank && start) begin
                repeat (DIGITS) run.push_back(CH_SPACE);
                run.push_back(CH_TAB);
            end
            run.push_back(CH_DOLLAR);
        end
        if (set_tabs && ch == CH_TAB) begin
            run.push_back(CH_CARET);
            ch = CH_I;
        end
        run.push_back(ch);
        at_line_start = nl;
        foreach (run[k]) begin
            expected_bytes.push_back(t_filt_byte'{out_byte: run[k],
                                                  last_of_run: (k == run.size() - 1)});
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        case (idx)
            CFG_NUMBER_NONBLANK:  set_nonblank = v;
            CFG_NUMBER_ALL:       set_all = v;
            CFG_SQUEEZE_BLANK:    set_squeeze = v;
            CFG_SHOW_NONPRINTING: set_nonprint = v;
            CFG_SHOW_ENDS:        set_ends = v;
            CFG_SHOW_TABS:        set_tabs = v;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [5:0] bits);
        write_reg(CFG_IDX_SPARE, 1'b1);
        write_reg(CFG_NUMBER_NONBLANK, bits[CFG_NUMBER_NONBLANK]);
        write_reg(CFG_NUMBER_ALL, bits[CFG_NUMBER_ALL]);
        write_reg(CFG_SQUEEZE_BLANK, bits[CFG_SQUEEZE_BLANK]);
        write_reg(CFG_SHOW_NONPRINTING, bits[CFG_SHOW_NONPRINTING]);
        write_reg(CFG_SHOW_ENDS, bits[CFG_SHOW_ENDS]);
        write_reg(CFG_SHOW_TABS, bits[CFG_SHOW_TABS]);
        write_reg(CFG_IDX_TOP, 1'($urandom_range(0, 1)));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic fof);
        pending_text.push_back(t_text_item'{data_byte: b, first_of_file: fof});
    endtask

    function automatic logic pick_fof();
        return ($urandom_range(0, 31) == 0);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(0, CH_CTRL_MAX));
            2: return CH_TAB;
            3: return CH_DEL;
            4: return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(CH_SPACE, CH_DEL - 1));
        endcase
    endfunction

    // Mostly whole lines of random content, with blank lines and stray bytes mixed in.
    task automatic queue_lines(input int count);
        int made;
        int len;
        made = 0;
        while (made < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    push_byte(CH_NL, pick_fof());
                    made++;
                end
                3: begin
                    push_byte(8'($urandom_range(0, 255)), pick_fof());
                    made++;
                end
                default: begin
                    len = $urandom_range(1, 8);
                    repeat (len) begin
                        push_byte(pick_byte(), pick_fof());
                        made++;
                    end
                    push_byte(CH_NL, pick_fof());
                    made++;
                end
            endcase
        end
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (pending_text.size() != 0 || in_if.valid || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The expected bytes of an item are worked out when it is offered; items are
    // taken strictly in order, so this matches the order of acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data_byte <= '0;
            in_if.first_of_file <= 1'b0;
            in_gap <= draw_wait();
        end else if (!in_if.valid || in_if.ready) begin
            if (in_gap != 0) begin
                in_gap <= in_gap - 1;
                in_if.valid <= 1'b0;
            end else if (pending_text.size() != 0) begin
                next_text = pending_text.pop_front();
                expand_byte(next_text);
                in_if.valid <= 1'b1;
                in_if.data_byte <= next_text.data_byte;
                in_if.first_of_file <= next_text.first_of_file;
                in_gap <= draw_wait();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_stall <= 0;
        end else if (out_if.valid && out_if.ready) begin
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_CAP) begin
                    $display("%0t: unexpected transfer: expected none, actual byte %h last %b",
                             $time, out_if.out_byte, out_if.last_of_run);
                end
            end else begin
                want = expected_bytes.pop_front();
                if (want.out_byte !== out_if.out_byte ||
                    want.last_of_run !== out_if.last_of_run) begin
                    mismatches++;
                    if (mismatches <= PRINT_CAP) begin
                        if (want.out_byte !== out_if.out_byte) begin
                            $display("%0t: out_byte mismatch: expected %h, actual %h",
                                     $time, want.out_byte, out_if.out_byte);
                        end
                        if (want.last_of_run !== out_if.last_of_run) begin
                            $display("%0t: last_of_run mismatch: expected %b, actual %b",
                                     $time, want.last_of_run, out_if.last_of_run);
                        end
                    end
                end
            end
            out_draw = draw_wait();
            if (out_draw == 0) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b0;
                out_stall <= out_draw - 1;
            end
        end else if (!out_if.ready) begin
            if (out_stall != 0) begin
                out_stall <= out_stall - 1;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [5:0] bits;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Plain pass-through of the extreme and special bytes.
        apply_settings(6'b000000);
        push_byte("a", 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(CH_DEL, 1'b0);
        push_byte(CH_TAB, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(CH_NL, 1'b0);
        settle();

        // Every option on: padded blank line, squeezed blanks, carets, high bytes.
        apply_settings(6'b111111);
        push_byte(CH_NL, 1'b1);
        push_byte(CH_NL, 1'b0);
        push_byte(CH_NL, 1'b0);
        push_byte("A", 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(CH_CTRL_MAX, 1'b0);
        push_byte(CH_DEL, 1'b0);
        push_byte(CH_TAB, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(CH_NL, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(CH_NL, 1'b0);
        push_byte(CH_NL, 1'b0);
        settle();

        // Squeeze off keeps the blank flag; every line numbered, ends marked.
        bits = '0;
        bits[CFG_NUMBER_ALL] = 1'b1;
        bits[CFG_SHOW_ENDS] = 1'b1;
        apply_settings(bits);
        push_byte(CH_NL, 1'b0);
        push_byte(CH_NL, 1'b0);
        push_byte("x", 1'b0);
        push_byte(CH_NL, 1'b0);
        push_byte(CH_TAB, 1'b1);
        settle();

        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                bits = 6'b000000;
            end else if (p == 1) begin
                bits = 6'b111111;
            end else begin
                bits = 6'($urandom_range(0, 63));
            end
            apply_settings(bits);
            quiet_phase = ($urandom_range(0, 3) == 0);
            queue_lines(PHASE_ITEMS);
            settle();
        end

        // A long run of numbered lines carries the count across several digits.
        bits = 6'($urandom_range(0, 63));
        bits[CFG_NUMBER_NONBLANK] = 1'b0;
        bits[CFG_NUMBER_ALL] = 1'b1;
        bits[CFG_SQUEEZE_BLANK] = 1'b0;
        apply_settings(bits);
        quiet_phase = 1'b0;
        push_byte(CH_NL, 1'b1);
        repeat (COUNT_LINES) begin
            if ($urandom_range(0, 4) == 0) push_byte(pick_byte(), 1'b0);
            push_byte(CH_NL, 1'b0);
        end
        settle();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/tslf_pkg.sv
hw/rtl/tslf_in_if.sv
hw/rtl/tslf_out_if.sv
hw/rtl/tslf_front.sv
hw/rtl/tslf_queue.sv
hw/rtl/tslf_back.sv
hw/rtl/text_stream_line_filter_unit.sv
tb/text_stream_line_filter_unit_tb.sv
